// File: rtl/sprite_quad_vertex_setup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sprite quad vertex setup block
// Concurrent checks sampled on the rising clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_SETUP_MACROS_SVH
`define SPRITE_QUAD_VERTEX_SETUP_MACROS_SVH

// same-cycle implication
`define SQVS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqvs: same-cycle check failed");

// next-cycle implication
`define SQVS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqvs: next-cycle check failed");

`endif

// File: rtl/sqvs_pkg.sv
// ----------------------------------------------------------------------------
// sqvs_pkg
// Types, constants and the sine table generator for the sprite quad setup.
// ----------------------------------------------------------------------------
`default_nettype none

package sqvs_pkg;

  localparam int TRIG_FRAC_BITS_DEF   = 15;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  localparam int POS_W  = 24;
  localparam int SIZE_W = 23;
  localparam int UV_W   = 17;
  localparam int OFF_W  = POS_W + 2;
  localparam int SAT_W  = POS_W + 3;

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_BL = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_TR = 2'd3;

  localparam int         CORNERS   = 4;
  localparam int         VERT_CNT_W = 3;
  localparam logic [VERT_CNT_W-1:0] LAST_VERT = 3'd5;
  localparam logic [1:0] VERT_CORNER [0:5] = '{
    CORNER_TL, CORNER_BL, CORNER_BR, CORNER_BR, CORNER_TR, CORNER_TL
  };

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  center_x;
    logic signed [POS_W-1:0]  center_y;
    logic        [SIZE_W-1:0] width;
    logic        [SIZE_W-1:0] height;
    logic        [15:0]       angle;
    logic        [15:0]       tex_u;
    logic        [15:0]       tex_v;
    logic        [15:0]       tex_w;
    logic        [15:0]       tex_h;
    logic        [31:0]       color;
    logic        [15:0]       texture_id;
    logic signed [15:0]       depth;
  } sprite_t;

  typedef struct packed {
    logic        [1:0]       corner;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic        [UV_W-1:0]  out_u;
    logic        [UV_W-1:0]  out_v;
    logic        [31:0]      out_color;
    logic        [15:0]      out_texture;
    logic signed [15:0]      out_depth;
    logic                    last;
  } vertex_t;

  // sine of a Q30 angle in [0, pi/2], rounded to Q1.frac; elaboration only
  function automatic longint unsigned sine_entry(input longint unsigned x, input int frac);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return ($unsigned(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sqvs_trig.sv
// ----------------------------------------------------------------------------
// sqvs_trig
// Quarter-wave sine table with two registered reads: sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvs_trig #(
  parameter int TRIG_FRAC_BITS   = sqvs_pkg::TRIG_FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = sqvs_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [15:0]                      angle,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

  localparam int MAG_W  = TRIG_FRAC_BITS + 1;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SCL_W  = 14 + IDX_W;

  logic [MAG_W-1:0] rom [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned ANG_Q30 =
      (sqvs_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    assign rom[k] = MAG_W'(sqvs_pkg::sine_entry(ANG_Q30, TRIG_FRAC_BITS));
  end

  logic [1:0]       quad_s;
  logic [1:0]       quad_c;
  logic [SCL_W-1:0] scaled;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_flip;
  logic [IDX_W-1:0] idx_s;
  logic [IDX_W-1:0] idx_c;
  logic [MAG_W-1:0] rd_s;
  logic [MAG_W-1:0] rd_c;
  logic             neg_s;
  logic             neg_c;
  logic signed [MAG_W:0] mag_s;
  logic signed [MAG_W:0] mag_c;

  assign quad_s   = angle[15:14];
  assign quad_c   = quad_s + 2'd1;
  assign scaled   = SCL_W'(angle[13:0]) * SCL_W'(SINE_TABLE_DEPTH);
  assign idx      = IDX_W'(scaled >> 14);
  assign idx_flip = IDX_W'(SINE_TABLE_DEPTH) - idx;
  assign idx_s    = quad_s[0] ? idx_flip : idx;
  assign idx_c    = quad_c[0] ? idx_flip : idx;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_s  <= rom[idx_s];
      rd_c  <= rom[idx_c];
      neg_s <= quad_s[1];
      neg_c <= quad_c[1];
    end
  end

  assign mag_s   = $signed({1'b0, rd_s});
  assign mag_c   = $signed({1'b0, rd_c});
  assign sin_val = neg_s ? -mag_s : mag_s;
  assign cos_val = neg_c ? -mag_c : mag_c;

endmodule

`default_nettype wire

// File: rtl/sqvs_corner.sv
// ----------------------------------------------------------------------------
// sqvs_corner
// Rotates the four half-size corners: products, then rounded offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvs_corner #(
  parameter int TRIG_FRAC_BITS = sqvs_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  en_prod,
  input  logic                                  en_off,
  input  logic signed [TRIG_FRAC_BITS+1:0]      sin_val,
  input  logic signed [TRIG_FRAC_BITS+1:0]      cos_val,
  input  logic        [sqvs_pkg::SIZE_W-1:0]    width,
  input  logic        [sqvs_pkg::SIZE_W-1:0]    height,
  output logic signed [sqvs_pkg::OFF_W-1:0]     off_x [sqvs_pkg::CORNERS],
  output logic signed [sqvs_pkg::OFF_W-1:0]     off_y [sqvs_pkg::CORNERS]
);

  localparam int PROD_W = TRIG_FRAC_BITS + 2 + sqvs_pkg::SIZE_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(64'd1 << TRIG_FRAC_BITS);

  logic signed [sqvs_pkg::SIZE_W:0] ws;
  logic signed [sqvs_pkg::SIZE_W:0] hs;
  logic signed [PROD_W-1:0] cw;
  logic signed [PROD_W-1:0] sh;
  logic signed [PROD_W-1:0] sw;
  logic signed [PROD_W-1:0] ch;
  logic signed [SUM_W-1:0]  cw_e;
  logic signed [SUM_W-1:0]  sh_e;
  logic signed [SUM_W-1:0]  sw_e;
  logic signed [SUM_W-1:0]  ch_e;
  logic signed [sqvs_pkg::OFF_W-1:0] off_x_next [sqvs_pkg::CORNERS];
  logic signed [sqvs_pkg::OFF_W-1:0] off_y_next [sqvs_pkg::CORNERS];

  function automatic logic signed [sqvs_pkg::OFF_W-1:0] round_off(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] b;
    b = v + BIAS;
    return sqvs_pkg::OFF_W'(b >>> (TRIG_FRAC_BITS + 1));
  endfunction

  assign ws = $signed({1'b0, width});
  assign hs = $signed({1'b0, height});

  always_ff @(posedge clk) begin
    if (en_prod) begin
      cw <= cos_val * ws;
      sh <= sin_val * hs;
      sw <= sin_val * ws;
      ch <= cos_val * hs;
    end
  end

  assign cw_e = SUM_W'(cw);
  assign sh_e = SUM_W'(sh);
  assign sw_e = SUM_W'(sw);
  assign ch_e = SUM_W'(ch);

  // x sign: + on the right edge, y sign: + on the top edge
  always_comb begin
    for (int k = 0; k < sqvs_pkg::CORNERS; k++) begin
      logic right;
      logic top;
      right = (2'(k) == sqvs_pkg::CORNER_BR) || (2'(k) == sqvs_pkg::CORNER_TR);
      top   = (2'(k) == sqvs_pkg::CORNER_TL) || (2'(k) == sqvs_pkg::CORNER_TR);
      off_x_next[k] = round_off((right ? cw_e : -cw_e) - (top ? sh_e : -sh_e));
      off_y_next[k] = round_off((right ? sw_e : -sw_e) + (top ? ch_e : -ch_e));
    end
  end

  always_ff @(posedge clk) begin
    if (en_off) begin
      off_x <= off_x_next;
      off_y <= off_y_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sqvs_emit.sv
// ----------------------------------------------------------------------------
// sqvs_emit
// Holds one rotated sprite and issues its six vertices through an output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvs_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  sqvs_pkg::sprite_t                 item,
  input  logic signed [sqvs_pkg::OFF_W-1:0] off_x [sqvs_pkg::CORNERS],
  input  logic signed [sqvs_pkg::OFF_W-1:0] off_y [sqvs_pkg::CORNERS],
  output logic                              ready,
  output logic                              vertex_valid,
  input  logic                              vertex_stall,
  output sqvs_pkg::vertex_t                 vertex
);

  logic                               active;
  logic [sqvs_pkg::VERT_CNT_W-1:0]    cnt;
  sqvs_pkg::sprite_t                  spr;
  logic signed [sqvs_pkg::OFF_W-1:0]  ox [sqvs_pkg::CORNERS];
  logic signed [sqvs_pkg::OFF_W-1:0]  oy [sqvs_pkg::CORNERS];
  logic [sqvs_pkg::UV_W-1:0]          u1;
  logic [sqvs_pkg::UV_W-1:0]          v1;

  logic                               out_load;
  logic                               load;
  logic                               at_last;
  logic [1:0]                         corner;
  logic signed [sqvs_pkg::SAT_W-1:0]  sum_x;
  logic signed [sqvs_pkg::SAT_W-1:0]  sum_y;
  sqvs_pkg::vertex_t                  vertex_next;

  function automatic logic signed [sqvs_pkg::POS_W-1:0] sat_pos(
    input logic signed [sqvs_pkg::SAT_W-1:0] v
  );
    if (v > sqvs_pkg::SAT_W'(sqvs_pkg::POS_MAX)) begin
      return sqvs_pkg::POS_MAX;
    end
    if (v < sqvs_pkg::SAT_W'(sqvs_pkg::POS_MIN)) begin
      return sqvs_pkg::POS_MIN;
    end
    return sqvs_pkg::POS_W'(v);
  endfunction

  assign at_last  = (cnt == sqvs_pkg::LAST_VERT);
  assign out_load = active && (!vertex_valid || !vertex_stall);
  assign ready    = !active || (out_load && at_last);
  assign load     = item_valid && ready;

  assign corner = sqvs_pkg::VERT_CORNER[cnt];
  assign sum_x  = sqvs_pkg::SAT_W'(spr.center_x) + sqvs_pkg::SAT_W'(ox[corner]);
  assign sum_y  = sqvs_pkg::SAT_W'(spr.center_y) + sqvs_pkg::SAT_W'(oy[corner]);

  always_comb begin
    vertex_next.corner      = corner;
    vertex_next.pos_x       = sat_pos(sum_x);
    vertex_next.pos_y       = sat_pos(sum_y);
    vertex_next.out_u       = (corner == sqvs_pkg::CORNER_BR || corner == sqvs_pkg::CORNER_TR)
                              ? u1 : {1'b0, spr.tex_u};
    vertex_next.out_v       = (corner == sqvs_pkg::CORNER_TL || corner == sqvs_pkg::CORNER_TR)
                              ? v1 : {1'b0, spr.tex_v};
    vertex_next.out_color   = spr.color;
    vertex_next.out_texture = spr.texture_id;
    vertex_next.out_depth   = spr.depth;
    vertex_next.last        = at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      cnt          <= '0;
      vertex_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (out_load && at_last) begin
        active <= 1'b0;
      end else if (out_load) begin
        cnt <= cnt + 1'b1;
      end
      if (out_load) begin
        vertex_valid <= 1'b1;
      end else if (!vertex_stall) begin
        vertex_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      spr <= item;
      ox  <= off_x;
      oy  <= off_y;
      u1  <= {1'b0, item.tex_u} + {1'b0, item.tex_w};
      v1  <= {1'b0, item.tex_v} + {1'b0, item.tex_h};
    end
    if (out_load) begin
      vertex <= vertex_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sprite_quad_vertex_setup.sv
// After the sprite beat, one vertex per cycle follows while vertex_stall is low.
// The sequencer loads the next sprite as it issues the prior sprite's last vertex.
// Pipeline: input reg, table read, products, corner offsets, vertex sequencer.
// Reset clears the stage valids and the sequencer; the sine table is constant logic.
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup
// Rotated sprite to six quad vertices (TL, BL, BR, BR, TR, TL).
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_quad_vertex_setup_macros.svh"

module sprite_quad_vertex_setup #(
  parameter int TRIG_FRAC_BITS   = sqvs_pkg::TRIG_FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = sqvs_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sprite_valid,
  output logic              sprite_stall,
  input  sqvs_pkg::sprite_t sprite,
  output logic              vertex_valid,
  input  logic              vertex_stall,
  output sqvs_pkg::vertex_t vertex
);

  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;
  logic emit_ready;

  sqvs_pkg::sprite_t s1;
  sqvs_pkg::sprite_t s2;
  sqvs_pkg::sprite_t s3;
  sqvs_pkg::sprite_t s4;

  logic signed [TRIG_FRAC_BITS+1:0]  sin_val;
  logic signed [TRIG_FRAC_BITS+1:0]  cos_val;
  logic signed [sqvs_pkg::OFF_W-1:0] off_x [sqvs_pkg::CORNERS];
  logic signed [sqvs_pkg::OFF_W-1:0] off_y [sqvs_pkg::CORNERS];

  assign rdy4 = !v4 || emit_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign sprite_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= sprite_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= sprite;
    if (rdy2) s2 <= s1;
    if (rdy3) s3 <= s2;
    if (rdy4) s4 <= s3;
  end

  sqvs_trig #(
    .TRIG_FRAC_BITS   (TRIG_FRAC_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_trig (
    .clk     (clk),
    .en      (rdy2),
    .angle   (s1.angle),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  sqvs_corner #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_corner (
    .clk     (clk),
    .en_prod (rdy3),
    .en_off  (rdy4),
    .sin_val (sin_val),
    .cos_val (cos_val),
    .width   (s2.width),
    .height  (s2.height),
    .off_x   (off_x),
    .off_y   (off_y)
  );

  sqvs_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (v4),
    .item         (s4),
    .off_x        (off_x),
    .off_y        (off_y),
    .ready        (emit_ready),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex)
  );

  `SQVS_ASSERT_IMP(a_stall_only_when_full, clk, rst, sprite_stall, v1 && v2 && v3 && v4)
  `SQVS_ASSERT_IMP(a_last_is_top_left, clk, rst, vertex_valid && vertex.last, vertex.corner == sqvs_pkg::CORNER_TL)
  `SQVS_ASSERT_NXT(a_sprite_runs_unbroken, clk, rst, vertex_valid && !vertex_stall && !vertex.last, vertex_valid)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: sprite quad vertex setup testbench
// Sends sprites to the block and checks each one against an in-bench
// predictor. The predictor builds its own quarter-wave sine table, rotates
// the four half-size corners, rounds, adds the centre and saturates. It then
// queues six expected vertices per sprite. A scoreboard compares every output
// beat field by field. Both ports idle and stall at random, with one stretch
// that runs at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int FRAC           = sqvs_pkg::TRIG_FRAC_BITS_DEF;
  localparam int DEPTH          = sqvs_pkg::SINE_TABLE_DEPTH_DEF;
  localparam int VERTS_PER_QUAD = 6;
  localparam int RANDOM_SPRITES = 270;
  localparam int FULL_RATE_RUN  = 90;
  localparam int SETTLE_CYCLES  = 12;

  class vertex_scoreboard;
    sqvs_pkg::vertex_t expected_q[$];
    longint            sin_lut[0:DEPTH];
    int                errors;
    int                sprites;
    int                vertices;
    bit [3:0]          quads_seen;

    // Q30 Taylor series, rounded to nearest Q1.FRAC
    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      for (int k = 0; k <= DEPTH; k++) begin
        x    = (sqvs_pkg::HALF_PI_Q30 * k) / DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        sin_lut[k] = (acc + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      end
      errors     = 0;
      sprites    = 0;
      vertices   = 0;
      quads_seen = '0;
    endfunction

    function longint sine_at(logic [15:0] a);
      longint unsigned idx;
      longint          mag;
      idx = (64'(a[13:0]) * DEPTH) >> 14;
      if (idx > DEPTH) begin
        idx = DEPTH;
      end
      mag = a[14] ? sin_lut[DEPTH - idx] : sin_lut[idx];
      return a[15] ? -mag : mag;
    endfunction

    // floor((v + 2^F) / 2^(F+1)): halving plus round half up
    function longint round_half(longint v);
      return (v + (64'sd1 <<< FRAC)) >>> (FRAC + 1);
    endfunction

    function logic signed [sqvs_pkg::POS_W-1:0] clamp_pos(longint v);
      if (v > sqvs_pkg::POS_MAX) begin
        return sqvs_pkg::POS_MAX;
      end
      if (v < sqvs_pkg::POS_MIN) begin
        return sqvs_pkg::POS_MIN;
      end
      return v[sqvs_pkg::POS_W-1:0];
    endfunction

    function void note_sprite(sqvs_pkg::sprite_t sp);
      longint                    sn;
      longint                    cs;
      longint                    wx;
      longint                    hy;
      logic [sqvs_pkg::UV_W-1:0] u_lo;
      logic [sqvs_pkg::UV_W-1:0] u_hi;
      logic [sqvs_pkg::UV_W-1:0] v_lo;
      logic [sqvs_pkg::UV_W-1:0] v_hi;
      logic [1:0]                cn;
      logic                      right;
      logic                      top;
      sqvs_pkg::vertex_t         vx;
      sn   = sine_at(sp.angle);
      cs   = sine_at(sp.angle + 16'd16384);
      u_lo = {1'b0, sp.tex_u};
      u_hi = {1'b0, sp.tex_u} + {1'b0, sp.tex_w};
      v_lo = {1'b0, sp.tex_v};
      v_hi = {1'b0, sp.tex_v} + {1'b0, sp.tex_h};
      for (int k = 0; k < VERTS_PER_QUAD; k++) begin
        cn    = sqvs_pkg::VERT_CORNER[k];
        right = (cn == sqvs_pkg::CORNER_BR) || (cn == sqvs_pkg::CORNER_TR);
        top   = (cn == sqvs_pkg::CORNER_TL) || (cn == sqvs_pkg::CORNER_TR);
        wx    = longint'(sp.width);
        hy    = longint'(sp.height);
        if (!right) begin
          wx = -wx;
        end
        if (!top) begin
          hy = -hy;
        end
        vx.corner      = cn;
        vx.pos_x       = clamp_pos(longint'(sp.center_x) + round_half(cs * wx - sn * hy));
        vx.pos_y       = clamp_pos(longint'(sp.center_y) + round_half(sn * wx + cs * hy));
        vx.out_u       = right ? u_hi : u_lo;
        vx.out_v       = top ? v_hi : v_lo;
        vx.out_color   = sp.color;
        vx.out_texture = sp.texture_id;
        vx.out_depth   = sp.depth;
        vx.last        = (k == VERTS_PER_QUAD - 1);
        expected_q.insert(expected_q.size(), vx);
      end
      quads_seen[sp.angle[15:14]] = 1'b1;
      sprites++;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_vertex(sqvs_pkg::vertex_t got);
      sqvs_pkg::vertex_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("vertex beat with nothing pending: %h", got));
        return;
      end
      want = expected_q.pop_front();
      vertices++;
      if (got.corner !== want.corner)
        report($sformatf("vertex %0d corner %0d, want %0d", vertices, got.corner, want.corner));
      if (got.pos_x !== want.pos_x)
        report($sformatf("vertex %0d pos_x %0d, want %0d", vertices, got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report($sformatf("vertex %0d pos_y %0d, want %0d", vertices, got.pos_y, want.pos_y));
      if (got.out_u !== want.out_u)
        report($sformatf("vertex %0d out_u %h, want %h", vertices, got.out_u, want.out_u));
      if (got.out_v !== want.out_v)
        report($sformatf("vertex %0d out_v %h, want %h", vertices, got.out_v, want.out_v));
      if (got.out_color !== want.out_color)
        report($sformatf("vertex %0d out_color %h, want %h", vertices, got.out_color,
                         want.out_color));
      if (got.out_texture !== want.out_texture)
        report($sformatf("vertex %0d out_texture %h, want %h", vertices, got.out_texture,
                         want.out_texture));
      if (got.out_depth !== want.out_depth)
        report($sformatf("vertex %0d out_depth %0d, want %0d", vertices, got.out_depth,
                         want.out_depth));
      if (got.last !== want.last)
        report($sformatf("vertex %0d last %b, want %b", vertices, got.last, want.last));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              sprite_valid = 1'b0;
  logic              sprite_stall;
  sqvs_pkg::sprite_t sprite       = '0;
  logic              vertex_valid;
  logic              vertex_stall = 1'b0;
  sqvs_pkg::vertex_t vertex;

  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;
  int directed_count = 0;

  vertex_scoreboard sb = new();

  sprite_quad_vertex_setup uut (
    .clk          (clk),
    .rst          (rst),
    .sprite_valid (sprite_valid),
    .sprite_stall (sprite_stall),
    .sprite       (sprite),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    vertex_stall <= receiver_idles && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && vertex_valid && !vertex_stall) begin
      sb.check_vertex(vertex);
    end
  end

  task send_sprite(input sqvs_pkg::sprite_t sp);
    int gap;
    gap = 0;
    if (sender_idles) begin
      while ($urandom_range(99) < 30) begin
        gap++;
      end
    end
    if (gap > 0) begin
      sprite_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sprite_valid <= 1'b1;
    sprite       <= sp;
    do @(posedge clk); while (sprite_stall);
    sb.note_sprite(sp);
  endtask

  // drop valid and hold off until every queued vertex has come back
  task wait_drained();
    sprite_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic sqvs_pkg::sprite_t rand_sprite();
    sqvs_pkg::sprite_t sp;
    int                pick;
    sp.center_x   = 24'($urandom);
    sp.center_y   = 24'($urandom);
    sp.width      = 23'($urandom);
    sp.height     = 23'($urandom);
    sp.angle      = 16'($urandom);
    sp.tex_u      = 16'($urandom);
    sp.tex_v      = 16'($urandom);
    sp.tex_w      = 16'($urandom);
    sp.tex_h      = 16'($urandom);
    sp.color      = $urandom;
    sp.texture_id = 16'($urandom);
    sp.depth      = 16'($urandom);
    pick = $urandom_range(9);
    if (pick < 6) begin
      // ordinary on-screen sprite
      sp.center_x = 24'($urandom_range(2097151)) - 24'd1048576;
      sp.center_y = 24'($urandom_range(2097151)) - 24'd1048576;
      sp.width    = 23'($urandom_range(65535));
      sp.height   = 23'($urandom_range(65535));
    end else if (pick < 8) begin
      // hugging the range limits, so corners saturate
      sp.center_x = $urandom_range(1) ? sqvs_pkg::POS_MAX - 24'($urandom_range(4096))
                                      : sqvs_pkg::POS_MIN + 24'($urandom_range(4096));
      sp.center_y = $urandom_range(1) ? sqvs_pkg::POS_MAX - 24'($urandom_range(4096))
                                      : sqvs_pkg::POS_MIN + 24'($urandom_range(4096));
      sp.width    = 23'($urandom_range(1048576));
      sp.height   = 23'($urandom_range(1048576));
    end
    if ($urandom_range(7) == 0) begin
      sp.angle = 16'($urandom_range(7)) << 13;
    end
    return sp;
  endfunction

  task run_directed();
    sqvs_pkg::sprite_t sp;
    logic [15:0]       dir_angles [8];
    dir_angles = '{16'd0, 16'd1, 16'd8192, 16'd16383,
                   16'd16384, 16'd32768, 16'd49152, 16'd65535};
    sp = '0;
    send_sprite(sp);
    foreach (dir_angles[i]) begin
      sp            = '0;
      sp.center_x   = 24'sh001234;
      sp.center_y   = -24'sh000F00;
      sp.width      = 23'h001000;
      sp.height     = 23'h000800;
      sp.angle      = dir_angles[i];
      sp.tex_u      = 16'h1000;
      sp.tex_v      = 16'h2000;
      sp.tex_w      = 16'h0400;
      sp.tex_h      = 16'h0800;
      sp.color      = 32'h11223344;
      sp.texture_id = 16'(i);
      send_sprite(sp);
    end
    // largest size, at the origin and at both range limits
    sp        = '0;
    sp.width  = '1;
    sp.height = '1;
    send_sprite(sp);
    sp.center_x = sqvs_pkg::POS_MAX;
    sp.center_y = sqvs_pkg::POS_MAX;
    send_sprite(sp);
    sp.center_x = sqvs_pkg::POS_MIN;
    sp.center_y = sqvs_pkg::POS_MIN;
    send_sprite(sp);
    sp.center_x = sqvs_pkg::POS_MAX;
    sp.center_y = sqvs_pkg::POS_MIN;
    sp.angle    = 16'd32768;
    send_sprite(sp);
    // UV, colour, texture and depth extremes
    sp            = '0;
    sp.width      = 23'h000100;
    sp.height     = 23'h000100;
    sp.tex_u      = '1;
    sp.tex_v      = '1;
    sp.tex_w      = '1;
    sp.tex_h      = '1;
    sp.color      = '1;
    sp.texture_id = '1;
    sp.depth      = 16'sh7FFF;
    send_sprite(sp);
    sp.tex_u      = '0;
    sp.tex_v      = '0;
    sp.color      = '0;
    sp.texture_id = '0;
    sp.depth      = 16'sh8000;
    send_sprite(sp);
    directed_count = sb.sprites;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst            <= 1'b0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    run_directed();
    wait_drained();

    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    for (int n = 0; n < RANDOM_SPRITES; n++) begin
      if (n == FULL_RATE_RUN) begin
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
      end
      if (n == 2 * FULL_RATE_RUN) begin
        wait_drained();
      end
      send_sprite(rand_sprite());
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d sprites (%0d directed), %0d vertices compared.",
             sb.sprites, directed_count, sb.vertices);
    $display("Angle quadrants hit %b; %0d field mismatches.", sb.quads_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d vertices still pending.", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
